>>> rtl/egsa_pkg.sv
// Shared codes, widths and defaults for the embedding gather/scatter-add unit.
package egsa_pkg;

  localparam int DefMaxRows = 1024;
  localparam int DefMaxDim  = 64;

  localparam int ModeW   = 2;
  localparam int RowW    = 10;
  localparam int ColW    = 6;
  localparam int WordW   = 32;
  localparam int RowLenW = 7;
  localparam int RowsW   = 11;
  localparam int CfgIdxW = 1;
  localparam int CfgW    = 11;

  localparam logic [ModeW-1:0] ModeWrite   = 2'd0;
  localparam logic [ModeW-1:0] ModeGather  = 2'd1;
  localparam logic [ModeW-1:0] ModeScatter = 2'd2;
  localparam logic [ModeW-1:0] ModeUnused  = 2'd3;

  localparam logic [CfgIdxW-1:0] RegRowLength = 1'b0;
  localparam logic [CfgIdxW-1:0] RegRowsInUse = 1'b1;

  localparam logic [RowLenW-1:0] RowLengthRst = 7'd64;
  localparam logic [RowsW-1:0]   RowsInUseRst = 11'd1024;

  localparam logic [WordW-1:0] DefaultNan = 32'hFFC0_0000;

endpackage

>>> rtl/egsa_store.sv
// Single-port-write, registered-read word store holding the embedding table.
module egsa_store import egsa_pkg::*; #(
  parameter longint Depth = 64'(DefMaxRows) * 64'(DefMaxDim),
  parameter int     AddrW = 16
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WordW-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WordW-1:0] rdata_o
);

  logic [WordW-1:0] mem [Depth];
  logic [WordW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/egsa_fpadd.sv
// Multi-cycle IEEE-754 single adder, round to nearest even, full subnormal support.
module egsa_fpadd import egsa_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [WordW-1:0] a_i,
  input  logic [WordW-1:0] b_i,
  output logic             done_o,
  output logic [WordW-1:0] sum_o
);

  typedef enum logic [2:0] {
    StIdle, StAlign, StAdd, StNorm, StRound, StDone
  } state_e;

  state_e state_q;
  logic        sign_q, zsign_q, sub_q;
  logic [9:0]  e_q;
  logic [26:0] ml_q, ms_q, m_q;
  logic [7:0]  d_q;
  logic [WordW-1:0] res_q;

  // unpack
  logic a_nan, b_nan, a_inf, b_inf;
  logic [7:0]  ea, eb;
  logic [26:0] ma, mb;
  logic        a_big;
  always_comb begin
    a_nan = (a_i[30:23] == 8'hFF) && (a_i[22:0] != '0);
    b_nan = (b_i[30:23] == 8'hFF) && (b_i[22:0] != '0);
    a_inf = (a_i[30:23] == 8'hFF) && (a_i[22:0] == '0);
    b_inf = (b_i[30:23] == 8'hFF) && (b_i[22:0] == '0);
    ea = (a_i[30:23] == '0) ? 8'd1 : a_i[30:23];
    eb = (b_i[30:23] == '0) ? 8'd1 : b_i[30:23];
    ma = {(a_i[30:23] != '0), a_i[22:0], 3'b000};
    mb = {(b_i[30:23] != '0), b_i[22:0], 3'b000};
    a_big = {ea, ma} >= {eb, mb};
  end

  // alignment with sticky
  logic [26:0] shifted, lost;
  always_comb begin
    if (d_q >= 8'd27) begin
      shifted = '0;
      lost    = ms_q;
    end else begin
      shifted = ms_q >> d_q;
      lost    = ms_q & ((27'd1 << d_q) - 27'd1);
    end
  end

  logic [27:0] sum28;
  assign sum28 = sub_q ? ({1'b0, ml_q} - {1'b0, ms_q}) : ({1'b0, ml_q} + {1'b0, ms_q});

  // rounding
  logic        up;
  logic [24:0] mant;
  logic [9:0]  e_r;
  logic [7:0]  ef;
  logic [22:0] ff;
  always_comb begin
    up   = m_q[2] & (m_q[1] | m_q[0] | m_q[3]);
    mant = {1'b0, m_q[26:3]} + {24'd0, up};
    e_r  = mant[24] ? e_q + 10'd1 : e_q;
    ff   = mant[24] ? mant[23:1] : mant[22:0];
    if (!mant[24] && !mant[23]) begin
      ef = 8'd0;
    end else begin
      ef = e_r[7:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      case (state_q)
        StIdle: begin
          if (start_i) begin
            zsign_q <= a_i[31] & b_i[31];
            sub_q   <= a_i[31] ^ b_i[31];
            if (a_nan) begin
              res_q   <= a_i | 32'h0040_0000;
              state_q <= StDone;
            end else if (b_nan) begin
              res_q   <= b_i | 32'h0040_0000;
              state_q <= StDone;
            end else if (a_inf && b_inf && (a_i[31] != b_i[31])) begin
              res_q   <= DefaultNan;
              state_q <= StDone;
            end else if (a_inf) begin
              res_q   <= a_i;
              state_q <= StDone;
            end else if (b_inf) begin
              res_q   <= b_i;
              state_q <= StDone;
            end else begin
              sign_q  <= a_big ? a_i[31] : b_i[31];
              e_q     <= {2'b00, a_big ? ea : eb};
              ml_q    <= a_big ? ma : mb;
              ms_q    <= a_big ? mb : ma;
              d_q     <= a_big ? ea - eb : eb - ea;
              state_q <= StAlign;
            end
          end
        end
        StAlign: begin
          ms_q    <= shifted | {26'd0, (lost != '0)};
          state_q <= StAdd;
        end
        StAdd: begin
          if (sum28 == '0) begin
            res_q   <= {zsign_q, 31'd0};
            state_q <= StDone;
          end else if (sum28[27]) begin
            m_q     <= {sum28[27:2], sum28[1] | sum28[0]};
            e_q     <= e_q + 10'd1;
            state_q <= StNorm;
          end else begin
            m_q     <= sum28[26:0];
            state_q <= StNorm;
          end
        end
        StNorm: begin
          // one bit a cycle until the hidden bit is set or the exponent floor is hit
          if (!m_q[26] && (e_q > 10'd1)) begin
            m_q <= {m_q[25:0], 1'b0};
            e_q <= e_q - 10'd1;
          end else begin
            state_q <= StRound;
          end
        end
        StRound: begin
          if (e_r >= 10'd255) begin
            res_q <= {sign_q, 8'hFF, 23'd0};
          end else begin
            res_q <= {sign_q, ef, ff};
          end
          state_q <= StDone;
        end
        StDone: begin
          state_q <= StIdle;
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign done_o = (state_q == StDone);
  assign sum_o  = res_q;

endmodule

>>> rtl/embedding_gather_scatter_add_unit.sv
// Top level of the embedding gather/scatter-add unit: control, config and store.
//
// One transaction at a time. A transaction is taken when start_i is high and
// busy_o is low. Writes give no result. Gathers issue the registered store
// read in the accept cycle and take its data in StGather; the result strobe
// result_valid_o rises at the same edge at which busy_o drops. Scatter-accumulate
// reads the element, runs it through a multi-cycle FP32 adder (align, add,
// a normalize loop of one bit per cycle, round) and writes it back; heavy
// cancellation lengthens the normalize loop, and NaN or infinity operands
// skip the adder datapath. Out-of-range indices give an error result in the
// cycle after the accept and leave the store alone; mode three is dropped.
// The receiver cannot stall: each result is flagged by result_valid_o for
// exactly one cycle. The store has no reset; reading an element before it is
// written gives unspecified data.
module embedding_gather_scatter_add_unit import egsa_pkg::*; #(
  parameter int MAX_ROWS = DefMaxRows,
  parameter int MAX_DIM  = DefMaxDim
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgW-1:0]    cfg_wdata_i,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [ModeW-1:0]   mode_i,
  input  logic [RowW-1:0]    row_index_i,
  input  logic [ColW-1:0]    column_index_i,
  input  logic [WordW-1:0]   element_value_i,
  input  logic               batch_end_i,
  output logic               result_valid_o,
  output logic [WordW-1:0]   read_value_o,
  output logic               index_error_o,
  output logic               batch_last_o
);

  localparam longint Depth = 64'(MAX_ROWS) * 64'(MAX_DIM);
  localparam int     AddrW = (Depth > 1) ? $clog2(Depth) : 1;

  typedef enum logic [1:0] {
    StIdle, StGather, StScRead, StScAdd
  } state_e;

  state_e state_q;

  // config registers
  logic [RowLenW-1:0] row_length_q;
  logic [RowsW-1:0]   rows_in_use_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_length_q  <= RowLengthRst;
      rows_in_use_q <= RowsInUseRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegRowLength: row_length_q  <= cfg_wdata_i[RowLenW-1:0];
        RegRowsInUse: rows_in_use_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // decode of the incoming transaction
  logic             accept;
  logic             idx_ok;
  logic [63:0]      addr_full;
  logic [AddrW-1:0] addr;
  assign accept    = start_i && (state_q == StIdle);
  assign idx_ok    = ({1'b0, row_index_i} < rows_in_use_q) &&
                     (32'(row_index_i) < 32'(MAX_ROWS)) &&
                     ({1'b0, column_index_i} < row_length_q) &&
                     (32'(column_index_i) < 32'(MAX_DIM));
  assign addr_full = 64'(row_index_i) * 64'(MAX_DIM) + 64'(column_index_i);
  assign addr      = addr_full[AddrW-1:0];

  logic [AddrW-1:0] addr_q;
  logic [WordW-1:0] value_q;
  logic             last_q;

  // store and adder hookups
  logic             st_we, st_re;
  logic [AddrW-1:0] st_waddr;
  logic [WordW-1:0] st_wdata, st_rdata;
  logic             add_start, add_done;
  logic [WordW-1:0] add_sum;

  assign st_re     = accept && idx_ok && ((mode_i == ModeGather) || (mode_i == ModeScatter));
  assign add_start = (state_q == StScRead);
  always_comb begin
    if (state_q == StScAdd) begin
      st_we    = add_done;
      st_waddr = addr_q;
      st_wdata = add_sum;
    end else begin
      st_we    = accept && idx_ok && (mode_i == ModeWrite);
      st_waddr = addr;
      st_wdata = element_value_i;
    end
  end

  egsa_store #(
    .Depth (Depth),
    .AddrW (AddrW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .re_i    (st_re),
    .raddr_i (addr),
    .rdata_o (st_rdata)
  );

  egsa_fpadd u_fpadd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (add_start),
    .a_i     (st_rdata),
    .b_i     (value_q),
    .done_o  (add_done),
    .sum_o   (add_sum)
  );

  // control and result register
  logic             res_valid_q;
  logic [WordW-1:0] res_value_q;
  logic             res_err_q, res_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= 1'b0;
      case (state_q)
        StIdle: begin
          if (accept && (mode_i != ModeUnused)) begin
            addr_q  <= addr;
            value_q <= element_value_i;
            last_q  <= batch_end_i;
            if (!idx_ok) begin
              res_valid_q <= 1'b1;
              res_value_q <= '0;
              res_err_q   <= 1'b1;
              res_last_q  <= batch_end_i;
            end else if (mode_i == ModeGather) begin
              state_q <= StGather;
            end else if (mode_i == ModeScatter) begin
              state_q <= StScRead;
            end
          end
        end
        StGather: begin
          res_valid_q <= 1'b1;
          res_value_q <= st_rdata;
          res_err_q   <= 1'b0;
          res_last_q  <= last_q;
          state_q     <= StIdle;
        end
        StScRead: begin
          state_q <= StScAdd;
        end
        StScAdd: begin
          if (add_done) begin
            state_q <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign busy_o         = (state_q != StIdle);
  assign result_valid_o = res_valid_q;
  assign read_value_o   = res_value_q;
  assign index_error_o  = res_err_q;
  assign batch_last_o   = res_last_q;

endmodule
